@@ rtl/utct_pkg.sv @@
// Shared types, constants and helper functions for the UTF-8 character translator.
`default_nettype none

package utct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int TBL_IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TBL_CNT_W     = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        MODE_DATA  = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // One group of result bytes produced by a single request
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  count;
        logic        str_last;
        logic        full;
    } grp_t;

    // Table update command
    typedef struct packed {
        logic        load;
        logic        clear;
        logic [31:0] pattern;
        logic [2:0]  pattern_len;
        logic [31:0] replace;
        logic [2:0]  replace_len;
    } tbl_wr_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if (b < 8'hC0) begin
            len = 3'd1;
        end else if (b < 8'hE0) begin
            len = 3'd2;
        end else if (b < 8'hF0) begin
            len = 3'd3;
        end else if (b < 8'hF8) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    function automatic logic [2:0] clamp_len(input logic [2:0] n);
        logic [2:0] len;
        if (n == 3'd0) begin
            len = 3'd1;
        end else if (n > 3'd4) begin
            len = 3'd4;
        end else begin
            len = n;
        end
        return len;
    endfunction

    function automatic logic [31:0] mask_bytes(input logic [31:0] v, input logic [2:0] n);
        logic [31:0] r;
        case (n)
            3'd1: r = {24'd0, v[7:0]};
            3'd2: r = {16'd0, v[15:0]};
            3'd3: r = {8'd0, v[23:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/utf8_char_translate_unit.sv @@
// Top level of the UTF-8 character translator: request register, character gathering, control.
// A request is registered; any result it yields then loads the output group register.
// Throughput: one request per cycle while m_ready is high and each yields at most one byte.
// A request's result group holds the output group register until its last byte is taken.
// Reset (aresetn low, synchronous) empties the request and result registers, drops any
// partly gathered character and sets the table count to zero; table contents are kept.
`default_nettype none

module utf8_char_translate_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_string_last,
    input  wire logic [31:0] s_pattern_char,
    input  wire logic [2:0]  s_pattern_len,
    input  wire logic [31:0] s_replace_char,
    input  wire logic [2:0]  s_replace_len,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_run_last,
    output logic             m_string_end,
    output logic             m_table_full
);

    logic        in_valid_reg;
    logic [1:0]  mode_reg;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic [31:0] pat_reg;
    logic [2:0]  pat_len_reg;
    logic [31:0] rep_reg;
    logic [2:0]  rep_len_reg;

    logic [23:0] pending_reg, pending_next;
    logic [1:0]  held_reg, held_next;
    logic [2:0]  expected_reg, expected_next;

    utct_pkg::mode_t   mode;
    utct_pkg::grp_t    grp;
    utct_pkg::tbl_wr_t wr;
    logic              produce;
    logic              advance;
    logic              grp_free;
    logic [2:0]        expected;
    logic [31:0]       ch;
    logic [2:0]        n;
    logic [2:0]        plen;
    logic [2:0]        rlen;
    logic [31:0]       pat_m;
    logic [31:0]       rep_m;
    logic [31:0]       key_char;
    logic [2:0]        key_len;
    logic              hit;
    logic [31:0]       hit_replace;
    logic [2:0]        hit_replace_len;
    logic              tbl_full;

    assign mode    = utct_pkg::mode_t'(mode_reg);
    assign advance = in_valid_reg && grp_free;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg    <= s_mode;
            data_reg    <= s_data_byte;
            last_reg    <= s_string_last;
            pat_reg     <= s_pattern_char;
            pat_len_reg <= s_pattern_len;
            rep_reg     <= s_replace_char;
            rep_len_reg <= s_replace_len;
        end
    end

    assign expected = (held_reg == 2'd0) ? utct_pkg::lead_length(data_reg) : expected_reg;
    assign ch       = {8'd0, pending_reg} | ({24'd0, data_reg} << {held_reg, 3'b000});
    assign n        = {1'b0, held_reg} + 3'd1;
    assign plen     = utct_pkg::clamp_len(pat_len_reg);
    assign rlen     = utct_pkg::clamp_len(rep_len_reg);
    assign pat_m    = utct_pkg::mask_bytes(pat_reg, plen);
    assign rep_m    = utct_pkg::mask_bytes(rep_reg, rlen);
    assign key_char = (mode == utct_pkg::MODE_LOAD) ? pat_m : ch;
    assign key_len  = (mode == utct_pkg::MODE_LOAD) ? plen : n;

    utct_table u_table (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .key_char        (key_char),
        .key_len         (key_len),
        .wr              (wr),
        .hit             (hit),
        .hit_replace     (hit_replace),
        .hit_replace_len (hit_replace_len),
        .full            (tbl_full)
    );

    always_comb begin
        pending_next  = pending_reg;
        held_next     = held_reg;
        expected_next = expected_reg;
        produce       = 1'b0;
        grp           = '0;
        wr            = '0;
        wr.pattern     = pat_m;
        wr.pattern_len = plen;
        wr.replace     = rep_m;
        wr.replace_len = rlen;
        case (mode)
            utct_pkg::MODE_DATA: begin
                if (n < expected && !last_reg) begin
                    pending_next  = ch[23:0];
                    held_next     = n[1:0];
                    expected_next = expected;
                end else begin
                    pending_next  = '0;
                    held_next     = '0;
                    expected_next = '0;
                    produce       = 1'b1;
                    grp.str_last  = last_reg;
                    if (n >= expected && hit) begin
                        grp.bytes = hit_replace;
                        grp.count = hit_replace_len;
                    end else begin
                        grp.bytes = ch;
                        grp.count = n;
                    end
                end
            end
            utct_pkg::MODE_LOAD: begin
                if (!hit) begin
                    if (tbl_full) begin
                        produce   = 1'b1;
                        grp.count = 3'd1;
                        grp.full  = 1'b1;
                    end else begin
                        wr.load = 1'b1;
                    end
                end
            end
            utct_pkg::MODE_CLEAR: begin
                wr.clear = 1'b1;
            end
            default: begin
            end
        endcase
        if (!advance) begin
            wr.load  = 1'b0;
            wr.clear = 1'b0;
            produce  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= '0;
            held_reg     <= '0;
            expected_reg <= '0;
        end else if (advance) begin
            pending_reg  <= pending_next;
            held_reg     <= held_next;
            expected_reg <= expected_next;
        end
    end

    utct_serializer u_serializer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (produce),
        .grp_in       (grp),
        .grp_free     (grp_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_string_end (m_string_end),
        .m_table_full (m_table_full)
    );

    a_partial_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg != 2'd0) |-> ({1'b0, held_reg} < expected_reg))
        else $error("gathered bytes reach expected length");

    a_request_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending request lost");

endmodule

`default_nettype wire

@@ rtl/utct_table.sv @@
// Mapping table: entry storage, parallel first-match lookup and fill count.
`default_nettype none

module utct_table (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [31:0]           key_char,
    input  wire logic [2:0]            key_len,
    input  wire utct_pkg::tbl_wr_t     wr,
    output logic                       hit,
    output logic [31:0]                hit_replace,
    output logic [2:0]                 hit_replace_len,
    output logic                       full
);

    localparam int N     = utct_pkg::TABLE_ENTRIES;
    localparam int IDX_W = utct_pkg::TBL_IDX_W;
    localparam int CNT_W = utct_pkg::TBL_CNT_W;

    logic [31:0]      pat_reg     [N];
    logic [2:0]       pat_len_reg [N];
    logic [31:0]      rep_reg     [N];
    logic [2:0]       rep_len_reg [N];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [N-1:0]     match;
    logic [IDX_W-1:0] sel;
    logic [IDX_W-1:0] wr_idx;

    assign wr_idx = count_reg[IDX_W-1:0];
    assign full   = (count_reg >= CNT_W'(N));

    always_comb begin
        for (int i = 0; i < N; i++) begin
            match[i] = (CNT_W'(i) < count_reg) && (pat_len_reg[i] == key_len)
                       && (pat_reg[i] == key_char);
        end
    end

    // lowest index wins
    always_comb begin
        sel = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (match[i]) begin
                sel = IDX_W'(i);
            end
        end
    end

    assign hit             = |match;
    assign hit_replace     = rep_reg[sel];
    assign hit_replace_len = rep_len_reg[sel];

    always_comb begin
        count_next = count_reg;
        if (wr.clear) begin
            count_next = '0;
        end else if (wr.load && !full) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.load && !wr.clear && !full) begin
            pat_reg[wr_idx]     <= wr.pattern;
            pat_len_reg[wr_idx] <= wr.pattern_len;
            rep_reg[wr_idx]     <= wr.replace;
            rep_len_reg[wr_idx] <= wr.replace_len;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(N))
        else $error("table count beyond capacity");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.clear |=> (count_reg == '0))
        else $error("table not empty after clear");

endmodule

`default_nettype wire

@@ rtl/utct_serializer.sv @@
// Result group register that sends its bytes out one per cycle while m_ready is high.
`default_nettype none

module utct_serializer (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire utct_pkg::grp_t    grp_in,
    output logic                   grp_free,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_out_byte,
    output logic                   m_run_last,
    output logic                   m_string_end,
    output logic                   m_table_full
);

    utct_pkg::grp_t grp_reg;
    logic           valid_reg;
    logic [1:0]     idx_reg;
    logic           last_byte;

    assign last_byte    = (({1'b0, idx_reg} + 3'd1) == grp_reg.count);
    assign m_valid      = valid_reg;
    assign m_out_byte   = 8'(grp_reg.bytes >> {idx_reg, 3'b000});
    assign m_run_last   = last_byte;
    assign m_string_end = last_byte && grp_reg.str_last;
    assign m_table_full = grp_reg.full;
    assign grp_free     = !valid_reg || (m_ready && last_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (valid_reg && m_ready) begin
            if (last_byte) begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grp_reg <= grp_in;
        end
    end

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ({1'b0, idx_reg} < grp_reg.count))
        else $error("byte index past group length");

endmodule

`default_nettype wire
